@@ src/modbus_frame_crc_checker_defines.svh @@
// Assertion macros for the Modbus frame CRC checker.
// Used by the top level; expects clk and rst in scope where expanded.
`ifndef MODBUS_FRAME_CRC_CHECKER_DEFINES_SVH
`define MODBUS_FRAME_CRC_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mfcc_pkg.sv @@
// Shared types and constants for the Modbus frame CRC checker.
// No dependencies; imported by mfcc_frame_state and the top level.
package mfcc_pkg;

  localparam int unsigned MaxFrameLen = 255;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CrcW        = 16;

  localparam logic [ByteW-1:0] MinFrameLen = 8'd3;
  localparam logic [CrcW-1:0]  CrcInit     = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly     = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_LONG    = 2'd3
  } frame_status_t;

  typedef struct packed {
    frame_status_t     status;
    logic [ByteW-1:0]  command;
    logic [ByteW-1:0]  length;
    logic [CrcW-1:0]   crc;
  } frame_result_t;

endpackage

@@ src/mfcc_frame_state.sv @@
// Per-frame state: running CRC-16/MODBUS, CRC history, length and command byte.
// Depends on mfcc_pkg; produces the end-of-frame result combinationally.
module mfcc_frame_state
  import mfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLen
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  output frame_result_t    result
);

  localparam logic [ByteW-1:0] MaxCount = ByteW'(MAX_FRAME_LEN);

  function automatic logic [CrcW-1:0] crc_add_byte(input logic [CrcW-1:0] crc_in,
                                                   input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic [CrcW-1:0]  running_crc;
  logic [CrcW-1:0]  crc_one_back;
  logic [ByteW-1:0] previous_byte;
  logic [ByteW-1:0] byte_count;
  logic [ByteW-1:0] first_byte;
  logic             overflow;

  logic [CrcW-1:0]  running_crc_next;
  logic [ByteW-1:0] byte_count_next;
  logic [ByteW-1:0] first_byte_next;
  logic             overflow_next;
  logic             at_max;
  logic             trailer_bad;

  always_comb begin
    running_crc_next = crc_add_byte(running_crc, data_byte);
    at_max           = (byte_count >= MaxCount);
    overflow_next    = overflow | at_max;
    byte_count_next  = at_max ? byte_count : byte_count + ByteW'(1);
    first_byte_next  = (byte_count == '0 && !overflow) ? data_byte : first_byte;
    trailer_bad      = (previous_byte != crc_one_back[ByteW-1:0]) ||
                       (data_byte != crc_one_back[CrcW-1:ByteW]);

    result.command = first_byte_next;
    result.length  = byte_count_next;
    result.crc     = crc_one_back;
    if (overflow_next) begin
      result.status = ST_LONG;
    end else if (byte_count_next < MinFrameLen) begin
      result.status = ST_SHORT;
    end else if (trailer_bad) begin
      result.status = ST_BAD_CRC;
    end else begin
      result.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      running_crc   <= CrcInit;
      crc_one_back  <= CrcInit;
      previous_byte <= '0;
      byte_count    <= '0;
      first_byte    <= '0;
      overflow      <= 1'b0;
    end else if (fire) begin
      running_crc   <= running_crc_next;
      crc_one_back  <= running_crc;
      previous_byte <= data_byte;
      byte_count    <= byte_count_next;
      first_byte    <= first_byte_next;
      overflow      <= overflow_next;
    end
  end

endmodule

@@ src/modbus_frame_crc_checker.sv @@
// Modbus RTU frame CRC checker: top level with stream ports and result register.
// Depends on mfcc_pkg, mfcc_frame_state and modbus_frame_crc_checker_defines.svh.
//
// Input channel (s_axis_*): one frame byte per transfer, s_axis_tlast on the
// final byte. The trailer is the CRC low byte then high byte.
// Output channel (m_axis_*): one transfer per frame, presented the cycle after
// the byte that carries tlast. tuser holds the frame status (0 ok, 1 short,
// 2 CRC mismatch, 3 too long); tdata holds command byte, length and the CRC
// over all bytes but the trailer.
// Throughput: one byte per cycle unless a result is stalled; the eight CRC bit
// steps per byte are one combinational XOR network feeding the running CRC.
// While a result waits with m_axis_tready low, s_axis_tready is held low, so a
// stalled receiver stalls the byte stream; with m_axis_tready high, a waiting
// result leaves and a new byte enters in the same cycle.
// Reset: synchronous, clears the frame state (CRC 0xFFFF, count zero) and
// drops any pending result. After a frame end the state returns to the same
// values, so frames follow each other with no gap.
`include "modbus_frame_crc_checker_defines.svh"

module modbus_frame_crc_checker
  import mfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLen
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] command_code, [15:8] frame_length,
                                           // [31:16] computed_crc
  output logic [1:0]       m_axis_tuser    // [1:0] frame_status
);

  logic          s_fire;
  frame_result_t frame_result;
  frame_result_t out_result;
  logic          out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  mfcc_frame_state #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .fire     (s_fire),
    .data_byte(s_axis_tdata),
    .last_byte(s_axis_tlast),
    .result   (frame_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tlast) begin
      out_result <= frame_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_result.status;
  assign m_axis_tdata  = {out_result.crc, out_result.length, out_result.command};

  `MFCC_ASSERT_NEXT(a_end_gives_result, s_fire && s_axis_tlast, m_axis_tvalid, "frame end lost")
  `MFCC_ASSERT_NEXT(a_no_spurious_result, s_fire && !s_axis_tlast && !m_axis_tvalid, !m_axis_tvalid, "result without frame end")
  `MFCC_ASSERT_NOW(a_ok_min_len, m_axis_tvalid && m_axis_tuser == ST_OK, m_axis_tdata[15:8] >= MinFrameLen, "ok frame too short")
  `MFCC_ASSERT_NOW(a_short_crc_init, m_axis_tvalid && m_axis_tuser == ST_SHORT, m_axis_tdata[31:16] == CrcInit, "short frame CRC not initial")

endmodule
